[src/vvau_pkg.sv]
// Types, constants and helper functions of the velocity Verlet axis update.
`timescale 1ns / 1ps
`default_nettype none

package vvau_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_BITS   = 16;
    localparam int INR_W     = 31;
    localparam int DIV_STEPS = 32;
    localparam int SUM_W     = DATA_W + 3;
    localparam int PROD_W    = DATA_W + DT_BITS + 1;
    localparam int PROD2_W   = PROD_W + DT_BITS;

    localparam logic [1:0] MODE_VEL   = 2'd1;
    localparam logic [1:0] MODE_FORCE = 2'd2;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_CORRECT = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] q_t;

    // Values of one axis after the predict rules, or unchanged for a correct command.
    typedef struct packed {
        logic cmd;
        logic is_vel;
        q_t   pos;
        q_t   vel;
        q_t   acc;
        q_t   frc;
    } base_t;

    // One stage of the restoring divider together with the item it belongs to.
    typedef struct packed {
        base_t              base;
        logic [INR_W-1:0]   rem;
        logic [DATA_W-1:0]  quo;
        logic [DATA_W-1:0]  num;
        logic [INR_W-1:0]   den;
        logic               neg;
        logic               ovf;
        logic               fz;
    } divst_t;

    typedef struct packed {
        q_t frc;
        q_t acc;
        q_t vel;
        q_t pos;
    } result_t;

    function automatic q_t sat32(input logic signed [SUM_W-1:0] x);
        q_t r;
        if (x > SUM_W'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (x < SUM_W'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    // One quotient bit: shift in the next dividend bit, subtract the divisor if it fits.
    function automatic divst_t div_step(input divst_t d);
        divst_t           r;
        logic [DATA_W-1:0] trial;
        logic              fits;
        r     = d;
        trial = {d.rem, d.num[DATA_W-1]};
        fits  = (trial >= {1'b0, d.den});
        if (fits) begin
            r.rem = INR_W'(trial - {1'b0, d.den});
        end else begin
            r.rem = trial[INR_W-1:0];
        end
        r.quo = {d.quo[DATA_W-2:0], fits};
        r.num = {d.num[DATA_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

`default_nettype wire

[src/velocity_verlet_axis_update_top.sv]
// Velocity Verlet update of one axis of one body, pipelined with a 32-stage divider.
`timescale 1ns / 1ps
`default_nettype none

// One axis word is accepted every clock cycle while the pipeline is not held. The pipeline
// depth comes from the 32 compare-subtract stages of the divider that forms force / inertia.
// Every word goes through all stages, so results keep input order. A result waiting at the
// output does not stop the input: a skid register takes one more word, and the pipeline holds
// only once both are full. time_step is written through cfg_we / cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce. It resets to 66.
module velocity_verlet_axis_update_top
    import vvau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // position, velocity, acceleration, force_req, imposed_value, inertia, one zero bit
    input  wire logic [191:0] s_axis_tdata,
    // cmd, axis_mode
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // new_position, new_velocity, new_acceleration, new_force
    output logic [127:0]      m_axis_tdata
);

    localparam int HI_SHIFT = DATA_W - FRAC_BITS;

    logic [DT_BITS-1:0]   time_step_reg;
    logic signed [DT_BITS:0] dt_s;
    logic                 pipe_en;

    // Stage 1: input word.
    logic                 s1_vld_reg;
    logic                 s1_cmd_reg;
    logic [1:0]           s1_mode_reg;
    q_t                   s1_pos_reg, s1_vel_reg, s1_acc_reg, s1_frc_reg, s1_imp_reg;
    logic [INR_W-1:0]     s1_inr_reg;

    // Stage 2: first products and divider setup.
    logic                 s2_vld_reg;
    logic                 s2_cmd_reg, s2_is_vel_reg, s2_is_force_reg;
    q_t                   s2_pos_reg, s2_vel_reg, s2_acc_reg, s2_frc_reg, s2_imp_reg;
    logic signed [PROD_W-1:0] s2_pv_reg, s2_adt_reg;
    logic signed [PROD_W-1:0] s2_pv_next, s2_adt_next;
    logic [INR_W-1:0]     s2_rem_reg, s2_den_reg;
    logic [DATA_W-1:0]    s2_num_reg;
    logic                 s2_neg_reg, s2_ovf_reg, s2_fz_reg;
    logic [DATA_W-1:0]    frc_abs, frc_hi;
    logic                 frc_zero;

    // Stage 3: second product and rounded terms.
    logic                 s3_vld_reg;
    logic                 s3_cmd_reg, s3_is_vel_reg, s3_is_force_reg;
    q_t                   s3_pos_reg, s3_vel_reg, s3_acc_reg, s3_frc_reg, s3_imp_reg;
    logic signed [PROD2_W:0] s3_aa_reg, s3_aa_next;
    logic signed [DATA_W:0]  s3_rv_reg, s3_rv_next;
    q_t                   s3_ra_reg, s3_ra_next;
    logic signed [PROD_W:0]  pv_rnd, adt_rnd;
    logic [INR_W-1:0]     s3_rem_reg, s3_den_reg;
    logic [DATA_W-1:0]    s3_num_reg;
    logic                 s3_neg_reg, s3_ovf_reg, s3_fz_reg;

    // Stage 4 and the divider steps.
    logic signed [PROD2_W:0] aa_rnd;
    q_t                   raa;
    base_t                base_next;
    divst_t               dv_next;
    divst_t               dv_reg [0:DIV_STEPS];
    logic [DIV_STEPS:0]   dv_vld_reg;

    // Finishing stages.
    divst_t               dv_last;
    logic                 f1_vld_reg, f2_vld_reg, fin_vld_reg;
    base_t                f1_base_reg, f2_base_reg;
    q_t                   f1_acc_reg, f1_acc_next, f2_acc_reg;
    logic signed [PROD_W-1:0] f2_prod_reg, f2_prod_next;
    logic signed [PROD_W:0]   prod_rnd;
    q_t                   vel_c;
    result_t              fin_res_reg, fin_res_next;

    // Output register and skid register.
    logic                 out_vld_reg, skid_vld_reg;
    result_t              out_res_reg, skid_res_reg;
    logic                 out_take;

    assign dt_s          = {1'b0, time_step_reg};
    assign pipe_en       = !skid_vld_reg;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= 16'd66;
        end else if (cfg_we) begin
            time_step_reg <= cfg_wdata;
        end
    end

    // Valid bits of the whole pipeline move together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[DIV_STEPS-1:0], s3_vld_reg};
            f1_vld_reg  <= dv_vld_reg[DIV_STEPS];
            f2_vld_reg  <= f1_vld_reg;
            fin_vld_reg <= f2_vld_reg;
        end
    end

    // Stage 2 logic.
    always_comb begin
        q_t sel_v;
        sel_v       = (s1_mode_reg == MODE_VEL) ? s1_imp_reg : s1_vel_reg;
        s2_pv_next  = sel_v * dt_s;
        s2_adt_next = s1_acc_reg * dt_s;
        frc_abs     = s1_frc_reg[DATA_W-1] ? DATA_W'(~s1_frc_reg + 32'sd1) : s1_frc_reg;
        frc_hi      = frc_abs >> HI_SHIFT;
        frc_zero    = (s1_frc_reg == '0);
    end

    // Stage 3 logic: round v*dt and a*dt/2, and form a*dt*dt.
    always_comb begin
        pv_rnd     = (PROD_W + 1)'(s2_pv_reg) + ((PROD_W + 1)'(1) <<< (DT_BITS - 1));
        adt_rnd    = (PROD_W + 1)'(s2_adt_reg) + ((PROD_W + 1)'(1) <<< DT_BITS);
        s3_rv_next = pv_rnd[DATA_W + DT_BITS:DT_BITS];
        s3_ra_next = adt_rnd[DATA_W + DT_BITS:DT_BITS + 1];
        s3_aa_next = s2_adt_reg * dt_s;
    end

    // Stage 4 logic: predict results, or the values a correct command starts from.
    always_comb begin
        aa_rnd = s3_aa_reg + ((PROD2_W + 1)'(1) <<< (2 * DT_BITS));
        raa    = aa_rnd[DATA_W + 2 * DT_BITS:2 * DT_BITS + 1];

        base_next.cmd    = s3_cmd_reg;
        base_next.is_vel = s3_is_vel_reg;
        base_next.pos    = s3_pos_reg;
        base_next.vel    = s3_vel_reg;
        base_next.acc    = s3_acc_reg;
        base_next.frc    = s3_frc_reg;
        if (s3_cmd_reg == CMD_PREDICT) begin
            if (s3_is_vel_reg) begin
                base_next.vel = s3_imp_reg;
                base_next.pos = sat32(SUM_W'(s3_pos_reg) + SUM_W'(s3_rv_reg));
                base_next.frc = '0;
            end else begin
                base_next.pos = sat32(SUM_W'(s3_pos_reg) + SUM_W'(s3_rv_reg) + SUM_W'(raa));
                base_next.vel = sat32(SUM_W'(s3_vel_reg) + SUM_W'(s3_ra_reg));
                if (s3_is_force_reg) begin
                    base_next.frc = s3_imp_reg;
                end
            end
        end

        dv_next.base = base_next;
        dv_next.rem  = s3_rem_reg;
        dv_next.quo  = '0;
        dv_next.num  = s3_num_reg;
        dv_next.den  = s3_den_reg;
        dv_next.neg  = s3_neg_reg;
        dv_next.ovf  = s3_ovf_reg;
        dv_next.fz   = s3_fz_reg;
    end

    // Finishing logic: saturate the quotient, then add acc*dt/2 to the velocity.
    assign dv_last = dv_reg[DIV_STEPS];

    always_comb begin
        if (dv_last.fz) begin
            f1_acc_next = '0;
        end else if (dv_last.ovf) begin
            f1_acc_next = dv_last.neg ? SAT_MIN : SAT_MAX;
        end else if (dv_last.neg) begin
            f1_acc_next = (dv_last.quo > 32'h8000_0000) ? SAT_MIN : q_t'(~dv_last.quo + 32'd1);
        end else begin
            f1_acc_next = (dv_last.quo > 32'h7fff_ffff) ? SAT_MAX : q_t'(dv_last.quo);
        end
        f2_prod_next = f1_acc_reg * dt_s;
    end

    always_comb begin
        prod_rnd = (PROD_W + 1)'(f2_prod_reg) + ((PROD_W + 1)'(1) <<< DT_BITS);
        vel_c    = sat32(SUM_W'(f2_base_reg.vel)
                         + SUM_W'(q_t'(prod_rnd[DATA_W + DT_BITS:DT_BITS + 1])));
        fin_res_next.pos = f2_base_reg.pos;
        fin_res_next.vel = f2_base_reg.vel;
        fin_res_next.acc = f2_base_reg.acc;
        fin_res_next.frc = f2_base_reg.frc;
        if (f2_base_reg.cmd == CMD_CORRECT && !f2_base_reg.is_vel) begin
            fin_res_next.vel = vel_c;
            fin_res_next.acc = f2_acc_reg;
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_cmd_reg  <= s_axis_tuser[0];
            s1_mode_reg <= s_axis_tuser[2:1];
            s1_pos_reg  <= s_axis_tdata[31:0];
            s1_vel_reg  <= s_axis_tdata[63:32];
            s1_acc_reg  <= s_axis_tdata[95:64];
            s1_frc_reg  <= s_axis_tdata[127:96];
            s1_imp_reg  <= s_axis_tdata[159:128];
            s1_inr_reg  <= s_axis_tdata[190:160];

            s2_cmd_reg      <= s1_cmd_reg;
            s2_is_vel_reg   <= (s1_mode_reg == MODE_VEL);
            s2_is_force_reg <= (s1_mode_reg == MODE_FORCE);
            s2_pos_reg      <= s1_pos_reg;
            s2_vel_reg      <= s1_vel_reg;
            s2_acc_reg      <= s1_acc_reg;
            s2_frc_reg      <= s1_frc_reg;
            s2_imp_reg      <= s1_imp_reg;
            s2_pv_reg       <= s2_pv_next;
            s2_adt_reg      <= s2_adt_next;
            s2_rem_reg      <= frc_hi[INR_W-1:0];
            s2_num_reg      <= frc_abs << FRAC_BITS;
            s2_den_reg      <= s1_inr_reg;
            s2_neg_reg      <= s1_frc_reg[DATA_W-1];
            s2_fz_reg       <= frc_zero;
            s2_ovf_reg      <= (frc_hi >= {1'b0, s1_inr_reg}) && !frc_zero;

            s3_cmd_reg      <= s2_cmd_reg;
            s3_is_vel_reg   <= s2_is_vel_reg;
            s3_is_force_reg <= s2_is_force_reg;
            s3_pos_reg      <= s2_pos_reg;
            s3_vel_reg      <= s2_vel_reg;
            s3_acc_reg      <= s2_acc_reg;
            s3_frc_reg      <= s2_frc_reg;
            s3_imp_reg      <= s2_imp_reg;
            s3_rv_reg       <= s3_rv_next;
            s3_ra_reg       <= s3_ra_next;
            s3_aa_reg       <= s3_aa_next;
            s3_rem_reg      <= s2_rem_reg;
            s3_num_reg      <= s2_num_reg;
            s3_den_reg      <= s2_den_reg;
            s3_neg_reg      <= s2_neg_reg;
            s3_ovf_reg      <= s2_ovf_reg;
            s3_fz_reg       <= s2_fz_reg;

            dv_reg[0] <= dv_next;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                dv_reg[k] <= div_step(dv_reg[k-1]);
            end

            f1_base_reg <= dv_last.base;
            f1_acc_reg  <= f1_acc_next;
            f2_base_reg <= f1_base_reg;
            f2_acc_reg  <= f1_acc_reg;
            f2_prod_reg <= f2_prod_next;
            fin_res_reg <= fin_res_next;
        end
    end

    // Output register with a skid register behind it.
    assign out_take = !out_vld_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_take) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= fin_vld_reg;
            end
        end else if (pipe_en && fin_vld_reg) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_res_reg <= skid_vld_reg ? skid_res_reg : fin_res_reg;
        end else if (pipe_en && fin_vld_reg) begin
            skid_res_reg <= fin_res_reg;
        end
    end

    // The skid register only fills behind a word the output side has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_axis_tready))
        else $error("skid register filled while the output was free");

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register holds a word ahead of an empty output register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> (fin_vld_reg == $past(fin_vld_reg)) && (f1_vld_reg == $past(f1_vld_reg)))
        else $error("pipeline moved while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld_reg[DIV_STEPS] && !dv_last.ovf && !dv_last.fz) |-> (dv_last.rem < dv_last.den))
        else $error("divider remainder not below the divisor");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the velocity Verlet axis update, with a predictor and random stalls.
`timescale 1ns / 1ps

module tb;
    import vvau_pkg::*;

    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [15:0] DT_RESET  = 16'd66;
    localparam int PHASE_WORDS = 190;

    typedef struct packed {
        logic             cmd;
        logic [1:0]       mode;
        q_t               pos;
        q_t               vel;
        q_t               acc;
        q_t               frc;
        q_t               imp;
        logic [INR_W-1:0] inr;
    } axis_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // position, velocity, acceleration, force_req, imposed_value, inertia, one zero bit
    logic [191:0] s_axis_tdata = '0;
    // cmd, axis_mode
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // new_position, new_velocity, new_acceleration, new_force
    logic [127:0] m_axis_tdata;

    result_t     pending_results[$];
    axis_word_t  dir_word[$];
    logic        dir_typed[$];
    result_t     dir_exp[$];
    logic [15:0] dt_model = DT_RESET;
    int          mismatches = 0;
    int          burst_left = 0;

    velocity_verlet_axis_update_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic q_t sat_q(input logic signed [79:0] x);
        q_t r;
        if (x > 80'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (x < 80'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Round to nearest with ties toward plus infinity.
    function automatic logic signed [79:0] round_shr(input logic signed [79:0] x, input int s);
        return (x + (80'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic result_t verlet_update(input axis_word_t w, input logic [15:0] dt);
        result_t r;
        logic signed [79:0] p, v, a, f, m, d, den, adt, quo;
        p = w.pos;
        v = w.vel;
        a = w.acc;
        f = w.frc;
        m = w.imp;
        d = 80'(dt);
        den = 80'(w.inr);
        r.pos = w.pos;
        r.vel = w.vel;
        r.acc = w.acc;
        r.frc = w.frc;
        if (w.cmd == CMD_PREDICT) begin
            if (w.mode == MODE_VEL) begin
                r.vel = w.imp;
                r.pos = sat_q(p + round_shr(m * d, DT_BITS));
                r.frc = '0;
            end else begin
                adt = a * d;
                r.pos = sat_q(p + round_shr(v * d, DT_BITS) + round_shr(adt * d, 2 * DT_BITS + 1));
                r.vel = sat_q(v + round_shr(adt, DT_BITS + 1));
                if (w.mode == MODE_FORCE) begin
                    r.frc = w.imp;
                end
            end
        end else if (w.mode != MODE_VEL) begin
            if (w.inr == '0) begin
                if (f > 0) begin
                    r.acc = SAT_MAX;
                end else if (f < 0) begin
                    r.acc = SAT_MIN;
                end else begin
                    r.acc = '0;
                end
            end else begin
                // Signed division truncates toward zero.
                quo = (f <<< 16) / den;
                r.acc = sat_q(quo);
            end
            a = r.acc;
            r.vel = sat_q(v + round_shr(a * d, DT_BITS + 1));
        end
        return r;
    endfunction

    function automatic axis_word_t make_word(input logic c, input logic [1:0] md, input q_t p,
                                             input q_t v, input q_t a, input q_t f, input q_t m,
                                             input logic [INR_W-1:0] n);
        axis_word_t w;
        w.cmd  = c;
        w.mode = md;
        w.pos  = p;
        w.vel  = v;
        w.acc  = a;
        w.frc  = f;
        w.imp  = m;
        w.inr  = n;
        return w;
    endfunction

    function automatic result_t make_result(input q_t p, input q_t v, input q_t a, input q_t f);
        result_t r;
        r.pos = p;
        r.vel = v;
        r.acc = a;
        r.frc = f;
        return r;
    endfunction

    function automatic void add_row(input axis_word_t w, input logic typed, input result_t r);
        dir_word.push_back(w);
        dir_typed.push_back(typed);
        dir_exp.push_back(r);
    endfunction

    function automatic q_t rand_q();
        q_t r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r = q_t'($urandom);
            4, 5:       r = q_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            6:          r = q_t'($urandom & 32'hFFFF_8000);
            7:          r = q_t'(int'($urandom_range(0, 2 ** 25)) - 2 ** 24);
            8: begin
                case ($urandom_range(0, 4))
                    0: r = SAT_MAX;
                    1: r = SAT_MIN;
                    2: r = '0;
                    3: r = -32'sd1;
                    default: r = 32'sd1;
                endcase
            end
            default: r = q_t'($urandom) >>> $urandom_range(0, 30);
        endcase
        return r;
    endfunction

    function automatic logic [INR_W-1:0] rand_inertia();
        logic [INR_W-1:0] n;
        case ($urandom_range(0, 19))
            0:          n = '0;
            1:          n = 31'd1;
            2:          n = '1;
            3, 4, 5, 6: n = INR_W'($urandom);
            7, 8, 9:    n = INR_W'($urandom_range(1, 255));
            default:    n = INR_W'($urandom_range(1, 2 ** 20));
        endcase
        return n;
    endfunction

    function automatic axis_word_t rand_word();
        axis_word_t w;
        w.cmd  = $urandom_range(0, 1) ? CMD_CORRECT : CMD_PREDICT;
        // Mode three is kept rare; it behaves like a free axis.
        w.mode = ($urandom_range(0, 15) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
        w.pos  = rand_q();
        w.vel  = rand_q();
        w.acc  = rand_q();
        w.frc  = rand_q();
        w.imp  = rand_q();
        w.inr  = rand_inertia();
        return w;
    endfunction

    // Drive one word in bursts of random length; the expectation is queued on acceptance.
    task automatic send_word(input axis_word_t w, input logic typed, input result_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {1'b0, w.inr, w.imp, w.frc, w.acc, w.vel, w.pos};
        s_axis_tuser  <= {w.mode, w.cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(typed ? r : verlet_update(w, dt_model));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic report_field(input string name, input q_t want, input q_t got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // The receiver switches between stall patterns for stretches of random length.
    initial begin : sink
        int style, span, k, n;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(20, 200);
            k     = $urandom_range(2, 6);
            for (n = 0; n < span; n++) begin
                @(negedge aclk);
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    2: m_axis_tready <= ((n % k) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                report_field("new_position", want.pos, got.pos);
                report_field("new_velocity", want.vel, got.vel);
                report_field("new_acceleration", want.acc, got.acc);
                report_field("new_force", want.frc, got.frc);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] dt_plan [5];
        int i, p;
        dt_plan[0] = 16'hFFFF;
        dt_plan[1] = 16'd1;
        dt_plan[2] = 16'($urandom_range(2, 65534));
        dt_plan[3] = 16'h8000;
        dt_plan[4] = DT_RESET;

        // Directed words, run with the step size left at its reset value.
        add_row(make_word(CMD_PREDICT, MODE_FREE, '0, '0, '0, '0, '0, '0), 1'b1,
                make_result('0, '0, '0, '0));
        add_row(make_word(CMD_CORRECT, MODE_VEL, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, 32'sd5, '0),
                1'b1, make_result(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
        add_row(make_word(CMD_CORRECT, MODE_FREE, 32'sd77, SAT_MAX, '0, 32'sd3, '0, '0), 1'b1,
                make_result(32'sd77, SAT_MAX, SAT_MAX, 32'sd3));
        add_row(make_word(CMD_CORRECT, MODE_FREE, -32'sd9, SAT_MIN, '0, -32'sd1, '0, '0), 1'b1,
                make_result(-32'sd9, SAT_MIN, SAT_MIN, -32'sd1));
        add_row(make_word(CMD_CORRECT, MODE_FORCE, 32'sd1, 32'sd12345, 32'sd8, '0, 32'sd4, '0),
                1'b1, make_result(32'sd1, 32'sd12345, '0, '0));
        add_row(make_word(CMD_PREDICT, MODE_VEL, 32'sd1000, 32'sd50, -32'sd7, 32'sd9, '0, '1),
                1'b1, make_result(32'sd1000, '0, -32'sd7, '0));
        add_row(make_word(CMD_PREDICT, MODE_FREE, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, '0, '1),
                1'b1, make_result(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN));
        add_row(make_word(CMD_PREDICT, MODE_FORCE, SAT_MIN, SAT_MIN, SAT_MIN, '0, SAT_MAX, '1),
                1'b1, make_result(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX));
        add_row(make_word(CMD_CORRECT, MODE_SPARE, '0, SAT_MAX, '0, SAT_MAX, '0, 31'd1), 1'b1,
                make_result('0, SAT_MAX, SAT_MAX, SAT_MAX));
        add_row(make_word(CMD_CORRECT, MODE_FORCE, '0, SAT_MIN, '0, SAT_MIN, '0, 31'd1), 1'b1,
                make_result('0, SAT_MIN, SAT_MIN, SAT_MIN));
        add_row(make_word(CMD_PREDICT, MODE_SPARE, 32'sd65536, -32'sd65536, 32'sd131072,
                          32'sd42, -32'sd42, 31'd65536), 1'b0, '0);
        add_row(make_word(CMD_PREDICT, MODE_VEL, SAT_MAX, 32'sd3, '0, 32'sd1, SAT_MAX, 31'd1),
                1'b0, '0);
        add_row(make_word(CMD_PREDICT, MODE_VEL, SAT_MIN, 32'sd3, '0, 32'sd1, SAT_MIN, 31'd1),
                1'b0, '0);
        add_row(make_word(CMD_CORRECT, MODE_FREE, 32'sd5, 32'sd100, '0, SAT_MIN, '0, '1), 1'b0,
                '0);
        add_row(make_word(CMD_CORRECT, MODE_FREE, 32'sd5, -32'sd100, '0, SAT_MAX, '0, '1), 1'b0,
                '0);
        add_row(make_word(CMD_CORRECT, MODE_FORCE, '0, '0, '0, -32'sd196608, '0, 31'd65536),
                1'b0, '0);
        add_row(make_word(CMD_CORRECT, MODE_FREE, '0, '0, '0, 32'sd7, '0, 31'd3), 1'b0, '0);
        add_row(make_word(CMD_CORRECT, MODE_FREE, '0, '0, '0, -32'sd7, '0, 31'd3), 1'b0, '0);
        add_row(make_word(CMD_PREDICT, MODE_FREE, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                          '1), 1'b0, '0);
        add_row(make_word(CMD_PREDICT, MODE_FORCE, 32'sh1234_5678, -32'sh0765_4321,
                          32'sh0ABC_DEF0, 32'sd11, -32'sd11, 31'd99), 1'b0, '0);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < dir_word.size(); i++) begin
            send_word(dir_word[i], dir_typed[i], dir_exp[i]);
        end

        // Each phase drains the pipeline before the step size is rewritten.
        for (p = 0; p < 5; p++) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            wait_idle();
            cfg_we    <= 1'b1;
            cfg_wdata <= dt_plan[p];
            dt_model = dt_plan[p];
            @(negedge aclk);
            cfg_we <= 1'b0;
            for (i = 0; i < PHASE_WORDS; i++) begin
                send_word(rand_word(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_idle();
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
